// ===== src/fpmd_pkg.sv =====
`timescale 1ns / 1ps

package fpmd_pkg;

    localparam int DATA_W    = 32;
    localparam int HALF_W    = 16;
    localparam int DIV_STEPS = 32;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // operation codes
    localparam logic [2:0] CMD_MULDIV  = 3'd0;
    localparam logic [2:0] CMD_FRAC16  = 3'd1;
    localparam logic [2:0] CMD_FRAC32  = 3'd2;
    localparam logic [2:0] CMD_DIV16   = 3'd3;
    localparam logic [2:0] CMD_RATIO32 = 3'd4;
    localparam logic [2:0] CMD_SPEED   = 3'd5;

    localparam logic [31:0] SAT_MAX     = 32'h7fff_ffff;
    localparam logic [31:0] ALL_ONES    = 32'hffff_ffff;
    localparam logic [31:0] CLAMP_Q16   = 32'h0000_ffff;
    localparam logic [15:0] FRAC_ONE    = 16'hffff;
    localparam logic [31:0] ROUND_HALF  = 32'h0000_8000;
    localparam logic [31:0] SPEED_SCALE = 32'd4660;
    localparam logic [31:0] SPEED_ROUND = 32'd128;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] opa;
        logic [31:0] opb;
        logic [31:0] opc;
    } t_in_item;

    typedef struct packed {
        logic [31:0] result;
        logic        saturated;
        logic        divide_by_zero;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic mul;
        logic shift;
        logic div_init;
        logic div_step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic div_needed;
        logic norm_req;
    } t_dp_status;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_CHK  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_FIN  = 5'b10000
    } t_state;

endpackage

// ===== src/fixed_point_muldiv_unit.sv =====
`timescale 1ns / 1ps
// channel   | handshake                 | payload
// ----------+---------------------------+----------------------------------
// input     | i_in_valid / o_in_ready   | i_in_data  (cmd, opa, opb, opc)
// output    | o_out_valid / i_out_ready | o_out_data (result, saturated,
//           |                           |             divide_by_zero)
//
// One transaction at a time. Frac ops go through MUL and CHK to the result load in
// FIN, which waits for a free output register; divide ops needing a quotient also
// run the 32 steps of the shared one-bit-per-cycle restoring divider, plus up to 16
// normalize shifts for ratio32. Input ready returns the cycle after the result load.
// Synchronous active-low reset clears the controller; no result is pending after it.
// A result waiting on i_out_ready does not block the next input transaction;
// only the final write into the output register waits for it.

module fixed_point_muldiv_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  fpmd_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output fpmd_pkg::t_out_item o_out_data
);
    import fpmd_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    fpmd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    fpmd_datapath u_datapath (
        .i_clk      (i_clk),
        .i_in_data  (i_in_data),
        .i_cmd      (dp_cmd),
        .o_status   (dp_status),
        .o_out_data (o_out_data)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after an accepted transaction");

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({dp_cmd.load, dp_cmd.mul, dp_cmd.shift,
                  dp_cmd.div_init, dp_cmd.div_step, dp_cmd.finish}))
        else $error("more than one datapath command at once");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.finish |-> (!o_out_valid || i_out_ready))
        else $error("pending result overwritten");

    a_div_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dp_cmd.div_step || dp_cmd.shift) |-> !o_in_ready)
        else $error("input ready while the divider is running");
`endif

endmodule

// ===== src/fpmd_ctrl.sv =====
`timescale 1ns / 1ps

module fpmd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  fpmd_pkg::t_dp_status i_status,
    output fpmd_pkg::t_dp_cmd   o_cmd
);
    import fpmd_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_CHK;
            end
            ST_CHK: begin
                if (!i_status.div_needed) begin
                    n_state = ST_FIN;
                end else if (i_status.norm_req) begin
                    o_cmd.shift = 1'b1;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_cnt          = '0;
                    n_state        = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== src/fpmd_datapath.sv =====
`timescale 1ns / 1ps

module fpmd_datapath (
    input  logic                 i_clk,
    input  fpmd_pkg::t_in_item   i_in_data,
    input  fpmd_pkg::t_dp_cmd    i_cmd,
    output fpmd_pkg::t_dp_status o_status,
    output fpmd_pkg::t_out_item  o_out_data
);
    import fpmd_pkg::*;

    logic [2:0]        r_cmd;
    logic [31:0]       r_a, r_b, r_c;
    logic              r_neg;
    logic [31:0]       r_mc;
    logic [63:0]       r_prod;
    logic [31:0]       r_p2;
    logic [31:0]       r_n, r_d;
    logic [31:0]       r_rem, r_quo, r_dsr;
    t_out_item         r_out;

    logic [31:0] ma, mb, mc;
    logic [31:0] mul_x, mul_y;
    logic [15:0] a16, b16;
    logic [31:0] b16_ext;
    logic [31:0] sp_sum, sp_s;
    logic [32:0] trial;
    logic        trial_ge;
    logic [32:0] trial_sub;
    logic        div_needed;
    logic [31:0] init_hi, init_lo, init_dsr;
    logic [31:0] mag, frac16_sum;
    t_out_item   res;

    assign a16     = r_a[15:0];
    assign b16     = r_b[15:0];
    assign b16_ext = {16'b0, b16};

    assign ma = r_a[31] ? (32'd0 - r_a) : r_a;
    assign mb = r_b[31] ? (32'd0 - r_b) : r_b;
    assign mc = r_c[31] ? (32'd0 - r_c) : r_c;

    // one 32x32 multiplier, operands chosen by operation; a second 16x16 product (r_p2) feeds frac32
    always_comb begin
        mul_x = {16'b0, a16};
        mul_y = b16_ext;
        if (r_cmd == CMD_MULDIV) begin
            mul_x = ma;
            mul_y = mb;
        end else if (r_cmd == CMD_SPEED) begin
            mul_x = {{16{a16[15]}}, a16};
            mul_y = SPEED_SCALE;
        end
    end

    // speed: rounded, then logical shift by 8 (only low 32 bits of the product matter)
    assign sp_sum = r_prod[31:0] + SPEED_ROUND;
    assign sp_s   = {8'b0, sp_sum[31:8]};

    always_comb begin
        case (r_cmd)
            CMD_MULDIV:  div_needed = (r_prod[63:32] < r_mc);
            CMD_DIV16:   div_needed = (b16 != 16'd0) && (a16 < b16);
            CMD_RATIO32: div_needed = (r_b != 32'd0) && (r_a < r_b);
            CMD_SPEED:   div_needed = (b16 != 16'd0);
            default:     div_needed = 1'b0;
        endcase
    end

    assign o_status.div_needed = div_needed;
    assign o_status.norm_req   = (r_cmd == CMD_RATIO32) && (r_d[31:16] != 16'd0);

    always_comb begin
        init_hi  = '0;
        init_lo  = {a16, 16'b0};
        init_dsr = b16_ext;
        case (r_cmd)
            CMD_MULDIV: begin
                init_hi  = r_prod[63:32];
                init_lo  = r_prod[31:0];
                init_dsr = r_mc;
            end
            CMD_RATIO32: begin
                init_lo  = {r_n[15:0], 16'b0};
                init_dsr = r_d;
            end
            CMD_SPEED: begin
                init_lo  = sp_s;
            end
            default: ;
        endcase
    end

    // restoring step; remainder stays below divisor
    assign trial     = {r_rem, r_quo[31]};
    assign trial_ge  = (trial >= {1'b0, r_dsr});
    assign trial_sub = trial - {1'b0, r_dsr};

    assign frac16_sum = r_prod[31:0] + ROUND_HALF;

    always_comb begin
        res = '0;
        mag = div_needed ? r_quo : SAT_MAX;
        unique case (r_cmd)
            CMD_MULDIV: begin
                res.result         = r_neg ? (32'd0 - mag) : mag;
                res.saturated      = !div_needed;
                res.divide_by_zero = (r_c == 32'd0);
            end
            CMD_FRAC16: begin
                res.result = (b16 == FRAC_ONE) ? {16'b0, a16} : {16'b0, frac16_sum[31:16]};
            end
            CMD_FRAC32: begin
                res.result = (b16 == FRAC_ONE) ? r_a : (r_p2 + {16'b0, r_prod[31:16]});
            end
            CMD_DIV16: begin
                res.divide_by_zero = (b16 == 16'd0);
                if (div_needed) begin
                    res.result = r_quo;
                end else if ((a16 != b16) && (b16 == 16'd0)) begin
                    res.result = '0;
                end else begin
                    res.result    = CLAMP_Q16;
                    res.saturated = 1'b1;
                end
            end
            CMD_RATIO32: begin
                res.divide_by_zero = (r_b == 32'd0);
                if (div_needed) begin
                    res.result = r_quo;
                end else begin
                    res.result    = CLAMP_Q16;
                    res.saturated = 1'b1;
                end
            end
            CMD_SPEED: begin
                if (!div_needed) begin
                    res.result         = ALL_ONES;
                    res.divide_by_zero = 1'b1;
                end else begin
                    res.result = r_quo + {31'b0, ((sp_s & b16_ext) > (sp_s >> 1))};
                end
            end
            default: res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_in_data.cmd;
            r_a   <= i_in_data.opa;
            r_b   <= i_in_data.opb;
            r_c   <= i_in_data.opc;
        end
        if (i_cmd.mul) begin
            r_prod <= 64'(mul_x) * 64'(mul_y);
            r_p2   <= {16'b0, r_a[31:16]} * b16_ext;
            r_neg  <= r_a[31] ^ r_b[31] ^ r_c[31];
            r_mc   <= mc;
            r_n    <= r_a;
            r_d    <= r_b;
        end
        if (i_cmd.shift) begin
            r_n <= r_n >> 1;
            r_d <= r_d >> 1;
        end
        if (i_cmd.div_init) begin
            r_rem <= init_hi;
            r_quo <= init_lo;
            r_dsr <= init_dsr;
        end
        if (i_cmd.div_step) begin
            r_rem <= trial_ge ? trial_sub[31:0] : trial[31:0];
            r_quo <= {r_quo[30:0], trial_ge};
        end
        if (i_cmd.finish) begin
            r_out <= res;
        end
    end

    assign o_out_data = r_out;

endmodule

// ===== test/fixed_point_muldiv_unit_tb.sv =====
`timescale 1ns / 1ps

module fixed_point_muldiv_unit_tb;
    import fpmd_pkg::*;

    // cmd codes with no operation behind them
    localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

    localparam int RANDOM_ITEMS = 1650;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        t_in_item  src;
        t_out_item res;
    } t_awaited;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item res;
    } t_stim_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    t_awaited  pending_results[$];
    t_stim_row stim_table[$];
    int        err_count = 0;
    int        idle_cycles = 0;

    fixed_point_muldiv_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // Q16 arithmetic as the unit is meant to compute it
    function automatic t_out_item arith_result(t_in_item it);
        t_out_item   r;
        logic [31:0] ma, mb, mc, q, s, dv, n, d;
        logic [63:0] prod;
        logic        neg;
        r = '0;
        case (it.cmd)
            CMD_MULDIV: begin
                neg  = it.opa[31] ^ it.opb[31] ^ it.opc[31];
                ma   = it.opa[31] ? -it.opa : it.opa;
                mb   = it.opb[31] ? -it.opb : it.opb;
                mc   = it.opc[31] ? -it.opc : it.opc;
                prod = 64'(ma) * 64'(mb);
                if (prod[63:32] < mc) begin
                    q = 32'(prod / 64'(mc));
                end else begin
                    q = SAT_MAX;
                    r.saturated = 1'b1;
                end
                r.result = neg ? -q : q;
                r.divide_by_zero = (it.opc == '0);
            end
            CMD_FRAC16: begin
                n  = {16'h0, it.opa[15:0]};
                dv = {16'h0, it.opb[15:0]};
                if (it.opb[15:0] == FRAC_ONE) begin
                    r.result = n;
                end else begin
                    q = n * dv + ROUND_HALF;
                    r.result = {16'h0, q[31:16]};
                end
            end
            CMD_FRAC32: begin
                dv = {16'h0, it.opb[15:0]};
                if (it.opb[15:0] == FRAC_ONE) begin
                    r.result = it.opa;
                end else begin
                    r.result = (it.opa >> 16) * dv + (({16'h0, it.opa[15:0]} * dv) >> 16);
                end
            end
            CMD_DIV16: begin
                n = {16'h0, it.opa[15:0]};
                d = {16'h0, it.opb[15:0]};
                r.divide_by_zero = (d == '0);
                if (n != d && d == '0) begin
                    r.result = '0;
                end else if (n < d) begin
                    r.result = (n << 16) / d;
                end else begin
                    r.result = CLAMP_Q16;
                    r.saturated = 1'b1;
                end
            end
            CMD_RATIO32: begin
                n = it.opa;
                d = it.opb;
                if (d == '0 || n >= d) begin
                    r.result = CLAMP_Q16;
                    r.saturated = 1'b1;
                    r.divide_by_zero = (d == '0);
                end else begin
                    while (n > CLAMP_Q16 || d > CLAMP_Q16) begin
                        n = n >> 1;
                        d = d >> 1;
                    end
                    r.result = (n << 16) / d;
                end
            end
            CMD_SPEED: begin
                s  = {{16{it.opa[15]}}, it.opa[15:0]};
                s  = (s * SPEED_SCALE + SPEED_ROUND) >> 8;
                dv = {16'h0, it.opb[15:0]};
                if (dv == '0) begin
                    r.result = ALL_ONES;
                    r.divide_by_zero = 1'b1;
                end else begin
                    q = s / dv;
                    if ((s & dv) > (s >> 1))
                        q = q + 1;
                    r.result = q;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return ALL_ONES;
            2: return $urandom_range(0, 1) ? SAT_MAX : ~SAT_MAX;
            3: return $urandom_range(0, 255);
            4: return $urandom_range(0, 65535);
            default: return $urandom();
        endcase
    endfunction

    // random transaction, mostly shaped so the non-clamping paths get exercised
    function automatic t_in_item rand_item();
        t_in_item    it;
        logic [31:0] mag, lo;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 3)
            it.cmd = $urandom_range(0, 1) ? CMD_UNUSED_6 : CMD_UNUSED_7;
        else
            it.cmd = 3'($urandom_range(CMD_MULDIV, CMD_SPEED));
        it.opa = rand_operand();
        it.opb = rand_operand();
        it.opc = rand_operand();
        case (it.cmd)
            CMD_MULDIV: begin
                if ($urandom_range(0, 3) != 0) begin
                    it.opa = $urandom();
                    it.opb = $urandom_range(0, 65535) >> $urandom_range(0, 15);
                    if ($urandom_range(0, 1))
                        it.opb = -it.opb;
                    mag = $urandom_range(32'h0001_0000, SAT_MAX) >> $urandom_range(0, 12);
                    it.opc = $urandom_range(0, 1) ? -mag : mag;
                end
            end
            CMD_FRAC16, CMD_FRAC32: begin
                if ($urandom_range(0, 9) == 0)
                    it.opb[15:0] = FRAC_ONE;
            end
            CMD_DIV16: begin
                if ($urandom_range(0, 9) < 7) begin
                    lo = $urandom_range(1, 65535);
                    it.opb = {16'($urandom()), lo[15:0]};
                    lo = $urandom_range(0, lo - 1);
                    it.opa = {16'($urandom()), lo[15:0]};
                end
            end
            CMD_RATIO32: begin
                if ($urandom_range(0, 9) < 7) begin
                    it.opb = $urandom() >> $urandom_range(0, 31);
                    if (it.opb != '0)
                        it.opa = $urandom_range(0, it.opb - 1);
                end
            end
            CMD_SPEED: begin
                if ($urandom_range(0, 9) < 8) begin
                    lo = $urandom_range(1, 65535) >> $urandom_range(0, 15);
                    if (lo == '0)
                        lo = 1;
                    it.opb = {16'($urandom()), lo[15:0]};
                end
            end
            default: ;
        endcase
        return it;
    endfunction

    task automatic add_row(input logic [2:0] cmd, input logic [31:0] a, input logic [31:0] b,
                           input logic [31:0] c, input bit typed, input logic [31:0] res,
                           input logic sat, input logic dbz);
        t_stim_row row;
        row.item  = '{cmd: cmd, opa: a, opb: b, opc: c};
        row.typed = typed;
        row.res   = '{result: res, saturated: sat, divide_by_zero: dbz};
        stim_table.push_back(row);
    endtask

    task automatic send_txn(input t_in_item item, input bit typed, input t_out_item fixed_res,
                            input int gap);
        t_awaited aw;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        aw.src = item;
        aw.res = typed ? fixed_res : arith_result(item);
        pending_results.push_back(aw);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input t_in_item src,
                                   input logic [31:0] expv, input logic [31:0] gotv);
        $display("mismatch %s: cmd %0d a %h b %h c %h expected %h got %h",
                 what, src.cmd, src.opa, src.opb, src.opc, expv, gotv);
        err_count++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_awaited aw;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", '0, '0, o_out_data.result);
            end else begin
                aw = pending_results.pop_front();
                if (o_out_data.result !== aw.res.result)
                    report_mismatch("result", aw.src, aw.res.result, o_out_data.result);
                if (o_out_data.saturated !== aw.res.saturated)
                    report_mismatch("saturated", aw.src, 32'(aw.res.saturated),
                                    32'(o_out_data.saturated));
                if (o_out_data.divide_by_zero !== aw.res.divide_by_zero)
                    report_mismatch("divide_by_zero", aw.src, 32'(aw.res.divide_by_zero),
                                    32'(o_out_data.divide_by_zero));
            end
        end
    end

    // watchdog: cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // receiver back-pressure, with occasional long runs of no stalls
    initial begin
        int run_len;
        int gap;
        forever begin
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(0, 8);
            i_out_ready <= 1'b1;
            repeat (run_len + 1) @(posedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    initial begin
        t_out_item none;
        int        gap;
        none = '0;

        // muldiv: zero divisor, sign on saturation, double negative, large quotient
        add_row(CMD_MULDIV, 32'h0, 32'h0, 32'h0, 1, SAT_MAX, 1'b1, 1'b1);
        add_row(CMD_MULDIV, 32'd5, 32'd7, 32'h0, 1, SAT_MAX, 1'b1, 1'b1);
        add_row(CMD_MULDIV, ALL_ONES, 32'd1, 32'h0, 1, 32'h8000_0001, 1'b1, 1'b1);
        add_row(CMD_MULDIV, ~SAT_MAX, ~SAT_MAX, 32'd1, 1, SAT_MAX, 1'b1, 1'b0);
        add_row(CMD_MULDIV, SAT_MAX, 32'd2, 32'd1, 1, 32'hffff_fffe, 1'b0, 1'b0);
        add_row(CMD_MULDIV, SAT_MAX, SAT_MAX, SAT_MAX, 0, '0, 1'b0, 1'b0);
        add_row(CMD_MULDIV, -32'sd100, 32'd3, -32'sd7, 0, '0, 1'b0, 1'b0);
        add_row(CMD_MULDIV, ALL_ONES, ALL_ONES, ~SAT_MAX, 0, '0, 1'b0, 1'b0);
        // frac16 / frac32: unity fraction passes, high halves ignored
        add_row(CMD_FRAC16, 32'habcd_1234, 32'h5555_ffff, ALL_ONES, 1, 32'h1234, 1'b0, 1'b0);
        add_row(CMD_FRAC16, 32'h0, 32'h0, 32'h0, 1, 32'h0, 1'b0, 1'b0);
        add_row(CMD_FRAC16, ALL_ONES, 32'hffff_fffe, 32'h0, 0, '0, 1'b0, 1'b0);
        add_row(CMD_FRAC32, ALL_ONES, 32'h0000_ffff, 32'h0, 1, ALL_ONES, 1'b0, 1'b0);
        add_row(CMD_FRAC32, ALL_ONES, 32'h0000_fffe, 32'h0, 0, '0, 1'b0, 1'b0);
        // div16: both zero, zero denominator, equal, over one
        add_row(CMD_DIV16, 32'hffff_0000, 32'h0, 32'h0, 1, CLAMP_Q16, 1'b1, 1'b1);
        add_row(CMD_DIV16, 32'd5, 32'hffff_0000, 32'h0, 1, 32'h0, 1'b0, 1'b1);
        add_row(CMD_DIV16, 32'h7fff, 32'h7fff, 32'h0, 1, CLAMP_Q16, 1'b1, 1'b0);
        add_row(CMD_DIV16, 32'hffff, 32'd1, 32'h0, 1, CLAMP_Q16, 1'b1, 1'b0);
        add_row(CMD_DIV16, 32'hffff_0001, 32'h1234_ffff, 32'h0, 0, '0, 1'b0, 1'b0);
        // ratio32: zero denominator, equal, full normalize
        add_row(CMD_RATIO32, 32'h0, 32'h0, 32'h0, 1, CLAMP_Q16, 1'b1, 1'b1);
        add_row(CMD_RATIO32, ALL_ONES, ALL_ONES, 32'h0, 1, CLAMP_Q16, 1'b1, 1'b0);
        add_row(CMD_RATIO32, 32'd1, 32'd2, 32'h0, 1, 32'h8000, 1'b0, 1'b0);
        add_row(CMD_RATIO32, SAT_MAX, ALL_ONES, 32'h0, 0, '0, 1'b0, 1'b0);
        // speed: zero divisor, extremes of the signed speed
        add_row(CMD_SPEED, 32'h0000_8000, 32'hffff_0000, 32'h0, 1, ALL_ONES, 1'b0, 1'b1);
        add_row(CMD_SPEED, 32'hffff_7fff, 32'd1, 32'h0, 0, '0, 1'b0, 1'b0);
        add_row(CMD_SPEED, 32'h0000_8000, 32'h0000_ffff, 32'h0, 0, '0, 1'b0, 1'b0);
        // unused codes
        add_row(CMD_UNUSED_6, ALL_ONES, ALL_ONES, ALL_ONES, 1, 32'h0, 1'b0, 1'b0);
        add_row(CMD_UNUSED_7, ALL_ONES, ALL_ONES, ALL_ONES, 1, 32'h0, 1'b0, 1'b0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_table[i])
            send_txn(stim_table[i].item, stim_table[i].typed, stim_table[i].res, pick_gap());

        // hold off until the unit has returned everything
        wait_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            gap = ((i % 256) < 40) ? 0 : pick_gap();
            send_txn(rand_item(), 0, none, gap);
            if (i == RANDOM_ITEMS / 2)
                wait_drained();
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (pending_results.size() != 0)
            report_mismatch("missing result", pending_results[0].src,
                            pending_results[0].res.result, '0);
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== fixed_point_muldiv_unit.f =====
src/fpmd_pkg.sv
src/fpmd_ctrl.sv
src/fpmd_datapath.sv
src/fixed_point_muldiv_unit.sv
test/fixed_point_muldiv_unit_tb.sv
